>>> rtl/kst_pkg.sv
// Shared types and constants for the spanning tree edge filter.
`timescale 1ns / 1ps

package kst_pkg;

    // Largest graph the label store can hold.
    localparam int MAX_VERTICES = 128;

    // Fixed field widths.
    localparam int VTX_W = 8;
    localparam int WGT_W = 16;
    localparam int TOT_W = 32;
    localparam int CFG_W = 8;

    // Label store: one entry per vertex number 0..MAX_VERTICES.
    localparam int LBL_DEPTH = MAX_VERTICES + 1;
    localparam int LBL_W     = $clog2(LBL_DEPTH);

    // Vertex counts and the accepted edge count share this width.
    localparam int CNT_W = (LBL_W > VTX_W) ? LBL_W : VTX_W;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_REJECT  = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_IGNORE  = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // Edge processing sequencer.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RDFROM,
        S_RDTO,
        S_SWEEP,
        S_SWLAST,
        S_DONE
    } t_state;

endpackage

>>> rtl/kst_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 129
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/kruskal_spanning_tree_edge_filter_unit.sv
// Spanning tree edge filter: checks sorted edges against per-vertex component labels.
// An accepted edge runs the relabel sweep, which reads one label store entry per cycle.
// A new request is taken the cycle after the previous result is loaded into the output
// register. Synchronous active-low reset returns every label to its own vertex number via
// per-entry valid bits; the first edge of a graph does the same.
`timescale 1ns / 1ps

module kruskal_spanning_tree_edge_filter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kst_pkg::CFG_W-1:0]         i_cfg_data,
    // Edge request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_first_edge,
    input  logic                              i_last_edge,
    input  logic [kst_pkg::VTX_W-1:0]         i_from_vertex,
    input  logic [kst_pkg::VTX_W-1:0]         i_to_vertex,
    input  logic signed [kst_pkg::WGT_W-1:0]  i_edge_weight,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [kst_pkg::VTX_W-1:0]         o_from_vertex_out,
    output logic [kst_pkg::VTX_W-1:0]         o_to_vertex_out,
    output logic signed [kst_pkg::WGT_W-1:0]  o_weight_out,
    output logic signed [kst_pkg::TOT_W-1:0]  o_total_weight,
    output logic                              o_tree_complete,
    output logic                              o_list_end
);

    kst_pkg::t_state  r_state;
    kst_pkg::t_state  n_state;
    kst_pkg::t_status r_status;

    // Captured request
    logic [kst_pkg::VTX_W-1:0]        r_from;
    logic [kst_pkg::VTX_W-1:0]        r_to;
    logic signed [kst_pkg::WGT_W-1:0] r_wgt;
    logic                             r_last;

    // Graph state
    logic [kst_pkg::CFG_W-1:0]        r_vcount;
    logic [kst_pkg::CNT_W-1:0]        r_count;
    logic signed [kst_pkg::TOT_W-1:0] r_total;
    logic [kst_pkg::LBL_DEPTH-1:0]    r_lvalid;

    // Label lookup and sweep
    logic [kst_pkg::LBL_W-1:0] r_keep;
    logic [kst_pkg::LBL_W-1:0] r_drop;
    logic [kst_pkg::LBL_W-1:0] r_idx;
    logic                      r_pend;
    logic [kst_pkg::LBL_W-1:0] r_rd_idx;
    logic                      r_rd_hit;

    // Output register
    logic                             r_out_valid;
    logic [1:0]                       r_out_status;
    logic [kst_pkg::VTX_W-1:0]        r_out_from;
    logic [kst_pkg::VTX_W-1:0]        r_out_to;
    logic signed [kst_pkg::WGT_W-1:0] r_out_wgt;
    logic signed [kst_pkg::TOT_W-1:0] r_out_total;
    logic                             r_out_complete;
    logic                             r_out_last;

    // Control signals
    logic                      in_acc;
    logic                      out_free;
    logic                      out_load;
    logic                      rd_en;
    logic [kst_pkg::LBL_W-1:0] rd_addr;
    logic                      wr_en;
    logic [kst_pkg::LBL_W-1:0] wr_addr;
    logic [kst_pkg::LBL_W-1:0] ram_rdata;
    logic [kst_pkg::LBL_W-1:0] label;
    logic [kst_pkg::CNT_W-1:0] eff_n;
    logic                      complete;
    logic                      invalid;
    logic                      sweep_end;
    logic signed [kst_pkg::TOT_W:0]   sum_ext;
    logic signed [kst_pkg::TOT_W-1:0] sum_sat;

    // Effective vertex count, clamped to the store size.
    assign eff_n = (kst_pkg::CNT_W'(r_vcount) > kst_pkg::CNT_W'(kst_pkg::MAX_VERTICES))
                 ? kst_pkg::CNT_W'(kst_pkg::MAX_VERTICES) : kst_pkg::CNT_W'(r_vcount);

    // The tree is complete once count + 1 reaches n.
    assign complete = ({1'b0, r_count} + (kst_pkg::CNT_W + 1)'(1)) >= {1'b0, eff_n};

    // Vertex numbers must lie in 1..n.
    assign invalid = (r_from == '0) || (r_to == '0)
                   || (kst_pkg::CNT_W'(r_from) > eff_n) || (kst_pkg::CNT_W'(r_to) > eff_n);

    // An entry never written since the last clear holds its own index.
    assign label = r_rd_hit ? ram_rdata : r_rd_idx;

    assign sweep_end = (r_idx == kst_pkg::LBL_W'(eff_n));

    // Saturating add of the edge weight to the running total.
    assign sum_ext = {r_total[kst_pkg::TOT_W-1], r_total}
                   + {{(kst_pkg::TOT_W + 1 - kst_pkg::WGT_W){r_wgt[kst_pkg::WGT_W-1]}}, r_wgt};
    always_comb begin
        if (sum_ext[kst_pkg::TOT_W] != sum_ext[kst_pkg::TOT_W-1]) begin
            sum_sat = sum_ext[kst_pkg::TOT_W] ? {1'b1, {(kst_pkg::TOT_W-1){1'b0}}}
                                              : {1'b0, {(kst_pkg::TOT_W-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[kst_pkg::TOT_W-1:0];
        end
    end

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            kst_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = kst_pkg::S_CHECK;
                end
            end
            kst_pkg::S_CHECK: begin
                n_state = (complete || invalid) ? kst_pkg::S_DONE : kst_pkg::S_RDFROM;
            end
            kst_pkg::S_RDFROM: begin
                n_state = kst_pkg::S_RDTO;
            end
            kst_pkg::S_RDTO: begin
                n_state = (label == r_keep) ? kst_pkg::S_DONE : kst_pkg::S_SWEEP;
            end
            kst_pkg::S_SWEEP: begin
                if (sweep_end) begin
                    n_state = kst_pkg::S_SWLAST;
                end
            end
            kst_pkg::S_SWLAST: begin
                n_state = kst_pkg::S_DONE;
            end
            kst_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = kst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kst_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: label store accesses, request stall and result load.
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        wr_en      = 1'b0;
        wr_addr    = r_rd_idx;
        out_load   = 1'b0;
        case (r_state)
            kst_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            kst_pkg::S_CHECK: begin
                rd_en   = !(complete || invalid);
                rd_addr = kst_pkg::LBL_W'(r_from);
            end
            kst_pkg::S_RDFROM: begin
                rd_en   = 1'b1;
                rd_addr = kst_pkg::LBL_W'(r_to);
            end
            kst_pkg::S_SWEEP: begin
                rd_en = 1'b1;
                wr_en = r_pend && (label == r_drop);
            end
            kst_pkg::S_SWLAST: begin
                wr_en = r_pend && (label == r_drop);
            end
            kst_pkg::S_DONE: begin
                out_load = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Label store.
    kst_ram #(
        .WIDTH (kst_pkg::LBL_W),
        .DEPTH (kst_pkg::LBL_DEPTH)
    ) u_label_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_keep),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kst_pkg::S_IDLE;
            r_vcount    <= kst_pkg::CFG_W'(1);
            r_count     <= '0;
            r_total     <= '0;
            r_lvalid    <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration write.
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end

            // A new graph restarts count, total and labels.
            if (in_acc && i_first_edge) begin
                r_count  <= '0;
                r_total  <= '0;
                r_lvalid <= '0;
            end

            // Accepted edge updates count and total.
            if (r_state == kst_pkg::S_RDTO && label != r_keep) begin
                r_count <= r_count + kst_pkg::CNT_W'(1);
                r_total <= sum_sat;
            end

            // Relabel writes mark their entries as holding stored data.
            if (wr_en) begin
                r_lvalid[wr_addr] <= 1'b1;
            end

            // Sweep pipeline flag: a read is in flight after the first sweep cycle.
            if (r_state == kst_pkg::S_RDTO) begin
                r_pend <= 1'b0;
            end else if (r_state == kst_pkg::S_SWEEP) begin
                r_pend <= 1'b1;
            end

            // Result channel valid.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        // Capture the request.
        if (in_acc) begin
            r_from <= i_from_vertex;
            r_to   <= i_to_vertex;
            r_wgt  <= i_edge_weight;
            r_last <= i_last_edge;
        end

        // Track which entry the read data belongs to.
        if (rd_en) begin
            r_rd_idx <= rd_addr;
            r_rd_hit <= r_lvalid[rd_addr];
        end

        // Decide the status and collect both labels.
        case (r_state)
            kst_pkg::S_CHECK: begin
                if (complete) begin
                    r_status <= kst_pkg::ST_IGNORE;
                end else if (invalid) begin
                    r_status <= kst_pkg::ST_INVALID;
                end
            end
            kst_pkg::S_RDFROM: begin
                r_keep <= label;
            end
            kst_pkg::S_RDTO: begin
                r_drop   <= label;
                r_idx    <= kst_pkg::LBL_W'(1);
                r_status <= (label == r_keep) ? kst_pkg::ST_REJECT : kst_pkg::ST_ACCEPT;
            end
            kst_pkg::S_SWEEP: begin
                r_idx <= r_idx + kst_pkg::LBL_W'(1);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase

        // Load the output register.
        if (out_load) begin
            r_out_status   <= r_status;
            r_out_from     <= r_from;
            r_out_to       <= r_to;
            r_out_wgt      <= r_wgt;
            r_out_total    <= r_total;
            r_out_complete <= complete;
            r_out_last     <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_from_vertex_out = r_out_from;
    assign o_to_vertex_out   = r_out_to;
    assign o_weight_out      = r_out_wgt;
    assign o_total_weight    = r_out_total;
    assign o_tree_complete   = r_out_complete;
    assign o_list_end        = r_out_last;

endmodule
